### hw/rtl/pcsad_pkg.sv
`default_nettype none

package pcsad_pkg;

  localparam int NumEvents   = 6;
  localparam int DefaultCpus = 16;
  localparam int DataW       = 64;
  localparam int CpuW        = 8;
  localparam int CountW      = 4;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 8;
  localparam int SlotW       = 3;

  typedef enum logic [CfgIdxW-1:0] {
    RegPmuEnable    = 3'd0,
    RegPmuVersion   = 3'd1,
    RegSlotCount    = 3'd2,
    RegCounterWidth = 3'd3,
    RegUnavailable  = 3'd4,
    RegEventRequest = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    CmdSample = 1'b0,
    CmdClear  = 1'b1
  } cmd_e;

  localparam logic [2:0] ArchBit [NumEvents] = '{3'd0, 3'd1, 3'd3, 3'd4, 3'd5, 3'd6};

  typedef struct packed {
    logic                 pmu_enable;
    logic [7:0]           pmu_version;
    logic [7:0]           slot_count;
    logic [7:0]           counter_width;
    logic [7:0]           unavailable;
    logic [NumEvents-1:0] event_request;
  } cfg_t;

  typedef struct packed {
    logic [NumEvents-1:0]            assigned;
    logic [NumEvents-1:0][SlotW-1:0] slot;
  } slot_map_t;

  typedef struct packed {
    logic sample;
    logic clear;
  } lane_ctl_t;

  function automatic slot_map_t assign_slots(input cfg_t cfg);
    slot_map_t        m;
    logic [SlotW-1:0] slot;
    m    = '0;
    slot = '0;
    for (int e = 0; e < NumEvents; e++) begin
      if (cfg.event_request[e] && !cfg.unavailable[ArchBit[e]] &&
          ({5'b0, slot} < cfg.slot_count)) begin
        m.slot[e]     = slot;
        m.assigned[e] = 1'b1;
        slot          = slot + 3'd1;
      end
    end
    return m;
  endfunction

  function automatic logic [DataW-1:0] width_mask(input logic [7:0] w);
    logic [DataW-1:0] m;
    if (w == 8'd0 || w >= 8'd64) begin
      m = '1;
    end else begin
      m = (64'd1 << w[5:0]) - 64'd1;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/pcsad_if.sv
`default_nettype none

interface pcsad_in_if import pcsad_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [CpuW-1:0]   cpu;
  logic [CountW-1:0] sample_count;
  logic [DataW-1:0]  slot_value_0;
  logic [DataW-1:0]  slot_value_1;
  logic [DataW-1:0]  slot_value_2;
  logic [DataW-1:0]  slot_value_3;
  logic [DataW-1:0]  slot_value_4;
  logic [DataW-1:0]  slot_value_5;

  modport source (
    output valid, cmd, cpu, sample_count,
    output slot_value_0, slot_value_1, slot_value_2,
    output slot_value_3, slot_value_4, slot_value_5,
    input  ready
  );
  modport sink (
    input  valid, cmd, cpu, sample_count,
    input  slot_value_0, slot_value_1, slot_value_2,
    input  slot_value_3, slot_value_4, slot_value_5,
    output ready
  );
endinterface

interface pcsad_out_if import pcsad_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DataW-1:0]     delta_0;
  logic [DataW-1:0]     delta_1;
  logic [DataW-1:0]     delta_2;
  logic [DataW-1:0]     delta_3;
  logic [DataW-1:0]     delta_4;
  logic [DataW-1:0]     delta_5;
  logic [NumEvents-1:0] active_mask;
  logic                 unit_available;

  modport source (
    output valid, delta_0, delta_1, delta_2, delta_3, delta_4, delta_5,
    output active_mask, unit_available,
    input  ready
  );
  modport sink (
    input  valid, delta_0, delta_1, delta_2, delta_3, delta_4, delta_5,
    input  active_mask, unit_available,
    output ready
  );
endinterface

interface pcsad_cfg_if import pcsad_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/pcsad_cfg.sv
`default_nettype none

module pcsad_cfg import pcsad_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pcsad_cfg_if.sink   cfg_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        RegPmuEnable:    cfg_d.pmu_enable    = cfg_i.data[0];
        RegPmuVersion:   cfg_d.pmu_version   = cfg_i.data;
        RegSlotCount:    cfg_d.slot_count    = cfg_i.data;
        RegCounterWidth: cfg_d.counter_width = cfg_i.data;
        RegUnavailable:  cfg_d.unavailable   = cfg_i.data;
        RegEventRequest: cfg_d.event_request = cfg_i.data[NumEvents-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pmu_enable    <= 1'b1;
      cfg_q.pmu_version   <= '0;
      cfg_q.slot_count    <= '0;
      cfg_q.counter_width <= '0;
      cfg_q.unavailable   <= '0;
      cfg_q.event_request <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/pcsad_lane.sv
`default_nettype none

module pcsad_lane import pcsad_pkg::*; #(
  parameter int CPUS  = DefaultCpus,
  parameter int AddrW = (CPUS > 1) ? $clog2(CPUS) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             take_i,
  input  wire logic             adv_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [DataW-1:0] now_i,
  input  wire lane_ctl_t        ctl_i,
  input  wire logic [DataW-1:0] mask_i,
  output logic      [DataW-1:0] delta_o
);

  logic [DataW-1:0] store_q [CPUS];
  logic [CPUS-1:0]  vld_q;
  logic [AddrW-1:0] addr_q;
  logic [DataW-1:0] now_q;
  logic [DataW-1:0] rd_q;
  logic             rdv_q;
  lane_ctl_t        ctl_q;
  logic             wr_en;
  logic             hit;
  logic [DataW-1:0] last;

  assign wr_en = adv_i & ctl_q.sample;
  assign hit   = adv_i & (ctl_q.sample | ctl_q.clear) & (addr_q == addr_i);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[addr_q] <= now_q;
    end
    if (take_i) begin
      rd_q   <= hit ? now_q : store_q[addr_i];
      now_q  <= now_i;
      addr_q <= addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      ctl_q <= '0;
      rdv_q <= 1'b0;
    end else begin
      if (adv_i && ctl_q.sample) begin
        vld_q[addr_q] <= 1'b1;
      end else if (adv_i && ctl_q.clear) begin
        vld_q[addr_q] <= 1'b0;
      end
      if (take_i) begin
        ctl_q <= ctl_i;
        rdv_q <= hit ? ctl_q.sample : vld_q[addr_i];
      end
    end
  end

  assign last    = rdv_q ? rd_q : '0;
  assign delta_o = (ctl_q.sample && last != '0) ? ((now_q - last) & mask_i) : '0;

endmodule

`default_nettype wire

### hw/rtl/pcsad_merge.sv
`default_nettype none

module pcsad_merge import pcsad_pkg::*; (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s1_valid_i,
  output logic                                     s1_adv_o,
  input  wire logic [NumEvents-1:0][DataW-1:0]     deltas_i,
  input  wire logic [NumEvents-1:0]                active_i,
  input  wire logic                                avail_i,
  pcsad_out_if.source                              out_o
);

  logic                            valid_q, valid_d;
  logic [NumEvents-1:0][DataW-1:0] deltas_q;
  logic [NumEvents-1:0]            active_q;
  logic                            avail_q;

  assign s1_adv_o = s1_valid_i & (~valid_q | out_o.ready);
  assign valid_d  = s1_adv_o | (valid_q & ~out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv_o) begin
      deltas_q <= deltas_i;
      active_q <= active_i;
      avail_q  <= avail_i;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.delta_0        = deltas_q[0];
  assign out_o.delta_1        = deltas_q[1];
  assign out_o.delta_2        = deltas_q[2];
  assign out_o.delta_3        = deltas_q[3];
  assign out_o.delta_4        = deltas_q[4];
  assign out_o.delta_5        = deltas_q[5];
  assign out_o.active_mask    = active_q;
  assign out_o.unit_available = avail_q;

endmodule

`default_nettype wire

### hw/rtl/perf_counter_slot_assign_and_delta_unit.sv
// Performance counter delta sampler. Each transaction on the input names a cpu and
// carries six raw slot readings; six event lanes, each with its own last-reading
// memory of CPUS entries, work side by side and one result transaction follows per
// input. Sustained rate is one transaction per cycle while the output takes results.
// There are two register stages (lane memory read, then wrapped subtract into the
// output register). While a result waits unaccepted, one more transaction is taken
// and the input then holds off until the result is taken. Reads of a cpu written by the
// preceding transaction are forwarded. Last readings are cleared at reset through
// per-entry valid flags, so no clearing pass is needed. Configuration writes take
// effect immediately and are expected only while idle.
`default_nettype none

module perf_counter_slot_assign_and_delta_unit import pcsad_pkg::*; #(
  parameter int CPUS = DefaultCpus
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pcsad_cfg_if.sink   cfg_i,
  pcsad_in_if.sink    in_i,
  pcsad_out_if.source out_o
);

  localparam int AddrW = (CPUS > 1) ? $clog2(CPUS) : 1;

  cfg_t                            cfg;
  slot_map_t                       smap;
  logic [DataW-1:0]                mask;
  logic [DataW-1:0]                slot_vals [NumEvents];
  logic                            avail;
  logic                            cpu_ok;
  logic                            take;
  logic                            s1_adv;
  logic                            s1_valid_q, s1_valid_d;
  logic [NumEvents-1:0]            active_q;
  logic                            avail_q;
  logic [NumEvents-1:0][DataW-1:0] deltas;
  lane_ctl_t [NumEvents-1:0]       ctl;
  logic [AddrW-1:0]                addr;

  pcsad_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign smap   = assign_slots(cfg);
  assign mask   = width_mask(cfg.counter_width);
  assign avail  = cfg.pmu_enable & (cfg.pmu_version != 8'd0) & (|smap.assigned);
  assign cpu_ok = {1'b0, in_i.cpu} < 9'(CPUS);
  assign addr   = in_i.cpu[AddrW-1:0];

  assign slot_vals[0] = in_i.slot_value_0;
  assign slot_vals[1] = in_i.slot_value_1;
  assign slot_vals[2] = in_i.slot_value_2;
  assign slot_vals[3] = in_i.slot_value_3;
  assign slot_vals[4] = in_i.slot_value_4;
  assign slot_vals[5] = in_i.slot_value_5;

  assign in_i.ready = ~s1_valid_q | s1_adv;
  assign take       = in_i.valid & in_i.ready;
  assign s1_valid_d = take | (s1_valid_q & ~s1_adv);

  always_comb begin
    for (int e = 0; e < NumEvents; e++) begin
      ctl[e].sample = avail & cpu_ok & (in_i.cmd == CmdSample) & smap.assigned[e] &
                      (CountW'(e) < in_i.sample_count);
      ctl[e].clear  = avail & cpu_ok & (in_i.cmd == CmdClear) & smap.assigned[e];
    end
  end

  for (genvar g = 0; g < NumEvents; g++) begin : g_lane
    pcsad_lane #(
      .CPUS  (CPUS),
      .AddrW (AddrW)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .take_i  (take),
      .adv_i   (s1_adv),
      .addr_i  (addr),
      .now_i   (slot_vals[smap.slot[g]] & mask),
      .ctl_i   (ctl[g]),
      .mask_i  (mask),
      .delta_o (deltas[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      active_q <= avail ? smap.assigned : '0;
      avail_q  <= avail;
    end
  end

  pcsad_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid_q),
    .s1_adv_o   (s1_adv),
    .deltas_i   (deltas),
    .active_i   (active_q),
    .avail_i    (avail_q),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

### dv/pcsad_delta_checker.sv
`default_nettype none

module pcsad_delta_checker import pcsad_pkg::*; #(
  parameter int CPUS = DefaultCpus
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pcsad_cfg_if      cfg_i,
  pcsad_in_if       in_i,
  pcsad_out_if      out_i,
  output int        fails_o,
  output int        pending_o,
  output int        checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    cmd_e                            cmd;
    logic [CpuW-1:0]                 cpu;
    logic [CountW-1:0]               count;
    logic [NumEvents-1:0][DataW-1:0] reading;
  } sample_t;

  typedef struct packed {
    logic [NumEvents-1:0][DataW-1:0] delta;
    logic [NumEvents-1:0]            active;
    logic                            avail;
  } deltas_t;

  localparam int EventArchBit [NumEvents] = '{0, 1, 3, 4, 5, 6};

  cfg_t             regs;
  logic [DataW-1:0] last_seen [CPUS][NumEvents];
  deltas_t          expected_deltas [$];
  int               fails;
  int               checked;

  function automatic deltas_t predict_deltas(input sample_t s);
    deltas_t          r;
    logic [DataW-1:0] mask;
    logic [DataW-1:0] now;
    logic [DataW-1:0] prev;
    logic [NumEvents-1:0] held;
    int unsigned      slot_of [NumEvents];
    int unsigned      next_slot;
    int unsigned      reported;
    logic             avail;
    r = '0;
    if (regs.counter_width == 8'd0 || regs.counter_width >= 8'd64) begin
      mask = '1;
    end else begin
      mask = (64'd1 << regs.counter_width) - 64'd1;
    end
    held      = '0;
    next_slot = 0;
    for (int e = 0; e < NumEvents; e++) begin
      slot_of[e] = 0;
      if (regs.event_request[e] && !regs.unavailable[EventArchBit[e]] &&
          next_slot < regs.slot_count) begin
        slot_of[e] = next_slot;
        held[e]    = 1'b1;
        next_slot++;
      end
    end
    avail    = regs.pmu_enable && regs.pmu_version != 8'd0 && held != '0;
    r.active = avail ? held : '0;
    r.avail  = avail;
    if (!avail || s.cpu >= CPUS) begin
      return r;
    end
    if (s.cmd == CmdClear) begin
      for (int e = 0; e < NumEvents; e++) begin
        if (held[e]) begin
          last_seen[s.cpu][e] = '0;
        end
      end
      return r;
    end
    reported = (s.count > NumEvents) ? NumEvents : s.count;
    for (int e = 0; e < reported; e++) begin
      if (held[e]) begin
        now                 = s.reading[slot_of[e]] & mask;
        prev                = last_seen[s.cpu][e];
        r.delta[e]          = (prev == '0) ? '0 : ((now - prev) & mask);
        last_seen[s.cpu][e] = now;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    sample_t s;
    deltas_t want;
    deltas_t got;
    if (!rst_ni) begin
      regs.pmu_enable    = 1'b1;
      regs.pmu_version   = '0;
      regs.slot_count    = '0;
      regs.counter_width = '0;
      regs.unavailable   = '0;
      regs.event_request = '1;
      for (int c = 0; c < CPUS; c++) begin
        for (int e = 0; e < NumEvents; e++) begin
          last_seen[c][e] = '0;
        end
      end
      expected_deltas.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          RegPmuEnable:    regs.pmu_enable    = cfg_i.data[0];
          RegPmuVersion:   regs.pmu_version   = cfg_i.data;
          RegSlotCount:    regs.slot_count    = cfg_i.data;
          RegCounterWidth: regs.counter_width = cfg_i.data;
          RegUnavailable:  regs.unavailable   = cfg_i.data;
          RegEventRequest: regs.event_request = cfg_i.data[NumEvents-1:0];
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready) begin
        s.cmd        = cmd_e'(in_i.cmd);
        s.cpu        = in_i.cpu;
        s.count      = in_i.sample_count;
        s.reading[0] = in_i.slot_value_0;
        s.reading[1] = in_i.slot_value_1;
        s.reading[2] = in_i.slot_value_2;
        s.reading[3] = in_i.slot_value_3;
        s.reading[4] = in_i.slot_value_4;
        s.reading[5] = in_i.slot_value_5;
        expected_deltas.push_back(predict_deltas(s));
      end
      if (out_i.valid && out_i.ready) begin
        got.delta[0] = out_i.delta_0;
        got.delta[1] = out_i.delta_1;
        got.delta[2] = out_i.delta_2;
        got.delta[3] = out_i.delta_3;
        got.delta[4] = out_i.delta_4;
        got.delta[5] = out_i.delta_5;
        got.active   = out_i.active_mask;
        got.avail    = out_i.unit_available;
        if (expected_deltas.size() == 0) begin
          fails++;
          $display("%0t: result with nothing expected, expected none actual %h", $time, got);
        end else begin
          want = expected_deltas.pop_front();
          checked++;
          for (int e = 0; e < NumEvents; e++) begin
            if (got.delta[e] !== want.delta[e]) begin
              fails++;
              $display("%0t: delta_%0d expected %h actual %h", $time, e, want.delta[e],
                       got.delta[e]);
            end
          end
          if (got.active !== want.active) begin
            fails++;
            $display("%0t: active_mask expected %h actual %h", $time, want.active, got.active);
          end
          if (got.avail !== want.avail) begin
            fails++;
            $display("%0t: unit_available expected %b actual %b", $time, want.avail,
                     got.avail);
          end
        end
      end
    end
    fails_o   <= fails;
    pending_o <= expected_deltas.size();
    checked_o <= checked;
  end

endmodule

`default_nettype wire

### dv/testbench.sv
`default_nettype none

module testbench import pcsad_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CpuCount      = DefaultCpus;
  localparam int StallLimit    = 2000;
  localparam int HoldoffCycles = 300;
  localparam int DrainCycles   = 8;
  localparam int RandPhases    = 8;
  localparam int PhaseItems    = 104;
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pcsad_cfg_if cfg_bus ();
  pcsad_in_if  in_bus ();
  pcsad_out_if out_bus ();

  int   fails;
  int   pending;
  int   checked;
  int   quiet_cycles;
  int   hold_reqs;
  int   holds_done;
  int   hold_left;
  logic src_steady;
  logic sink_steady;
  int   n_samples;
  int   n_clears;
  int   n_absent;
  int   n_settings;

  logic [DataW-1:0] prev_reading [NumEvents];

  perf_counter_slot_assign_and_delta_unit #(.CPUS(CpuCount)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  pcsad_delta_checker #(.CPUS(CpuCount)) checker_u (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_bus),
    .in_i      (in_bus),
    .out_i     (out_bus),
    .fails_o   (fails),
    .pending_o (pending),
    .checked_o (checked)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      hold_left     <= 0;
      holds_done    <= 0;
    end else if (hold_left != 0) begin
      out_bus.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (holds_done != hold_reqs) begin
      out_bus.ready <= 1'b0;
      holds_done    <= holds_done + 1;
      hold_left     <= HoldoffCycles;
    end else begin
      out_bus.ready <= sink_steady || ($urandom_range(0, 99) >= 31);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [NumEvents-1:0][DataW-1:0] ramp(input logic [DataW-1:0] base,
                                                          input logic [DataW-1:0] step);
    logic [NumEvents-1:0][DataW-1:0] v;
    for (int k = 0; k < NumEvents; k++) begin
      v[k] = base + step * k;
    end
    return v;
  endfunction

  function automatic logic [DataW-1:0] next_reading(input int k);
    int unsigned      pick;
    logic [DataW-1:0] r;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      r = '0;
    end else if (pick < 13) begin
      r = '1;
    end else if (pick < 48) begin
      r = {$urandom, $urandom};
    end else begin
      r = prev_reading[k] + $urandom_range(0, 5000);
    end
    prev_reading[k] = r;
    return r;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
  endtask

  task automatic set_regs(input logic [7:0] en, input logic [7:0] ver, input logic [7:0] gc,
                          input logic [7:0] cw, input logic [7:0] um, input logic [7:0] rq,
                          input logic spare);
    if (spare) begin
      write_reg(RegSpareLo, 8'($urandom));
      write_reg(RegSpareHi, 8'($urandom));
    end
    write_reg(RegPmuEnable, en);
    write_reg(RegPmuVersion, ver);
    write_reg(RegSlotCount, gc);
    write_reg(RegCounterWidth, cw);
    write_reg(RegUnavailable, um);
    write_reg(RegEventRequest, rq);
    cfg_bus.valid <= 1'b0;
    n_settings++;
  endtask

  task automatic send(input cmd_e c, input logic [CpuW-1:0] cpu,
                      input logic [CountW-1:0] cnt,
                      input logic [NumEvents-1:0][DataW-1:0] v);
    in_bus.valid        <= 1'b1;
    in_bus.cmd          <= c;
    in_bus.cpu          <= cpu;
    in_bus.sample_count <= cnt;
    in_bus.slot_value_0 <= v[0];
    in_bus.slot_value_1 <= v[1];
    in_bus.slot_value_2 <= v[2];
    in_bus.slot_value_3 <= v[3];
    in_bus.slot_value_4 <= v[4];
    in_bus.slot_value_5 <= v[5];
    do @(posedge clk_i); while (!in_bus.ready);
    if (c == CmdClear) begin
      n_clears++;
    end else begin
      n_samples++;
    end
    if (cpu >= CpuCount) begin
      n_absent++;
    end
    if (!src_steady && $urandom_range(0, 99) < 31) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // drop valid, let every expected result drain, then allow the pipeline to empty
  task automatic settle();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic random_regs();
    logic [7:0] en;
    logic [7:0] ver;
    logic [7:0] gc;
    logic [7:0] cw;
    logic [7:0] um;
    logic [7:0] rq;
    en  = {7'($urandom), 1'($urandom_range(0, 9) != 0)};
    ver = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(1, 255)) : 8'd0;
    case ($urandom_range(0, 9))
      0:       gc = 8'd0;
      1:       gc = 8'd255;
      2:       gc = 8'($urandom_range(7, 254));
      default: gc = 8'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 4))
      0, 1:    cw = 8'd0;
      2:       cw = 8'($urandom_range(64, 255));
      default: cw = 8'($urandom_range(1, 63));
    endcase
    um = $urandom_range(0, 1) ? 8'd0 : 8'($urandom & $urandom);
    rq = $urandom_range(0, 1) ? {2'($urandom), 6'h3F} : 8'($urandom);
    set_regs(en, ver, gc, cw, um, rq, $urandom_range(0, 3) == 0);
  endtask

  task automatic random_item();
    int unsigned                     pick;
    logic [CpuW-1:0]                 cpu;
    logic [CountW-1:0]               cnt;
    logic [NumEvents-1:0][DataW-1:0] v;
    pick = $urandom_range(0, 99);
    cpu  = ($urandom_range(0, 9) < 7) ? CpuW'($urandom_range(0, 3)) :
                                        CpuW'($urandom_range(0, CpuCount - 1));
    cnt  = ($urandom_range(0, 9) < 7) ? CountW'(NumEvents) : CountW'($urandom_range(0, 15));
    for (int k = 0; k < NumEvents; k++) begin
      v[k] = next_reading(k);
    end
    if (pick < 8) begin
      send(CmdClear, cpu, cnt, v);
    end else if (pick < 15) begin
      send(cmd_e'($urandom_range(0, 1)), CpuW'($urandom_range(0, 255)),
           CountW'($urandom_range(0, 15)), v);
    end else begin
      send(CmdSample, cpu, cnt, v);
    end
  endtask

  initial begin
    in_bus.valid        = 1'b0;
    in_bus.cmd          = CmdSample;
    in_bus.cpu          = '0;
    in_bus.sample_count = '0;
    in_bus.slot_value_0 = '0;
    in_bus.slot_value_1 = '0;
    in_bus.slot_value_2 = '0;
    in_bus.slot_value_3 = '0;
    in_bus.slot_value_4 = '0;
    in_bus.slot_value_5 = '0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = RegPmuEnable;
    cfg_bus.data        = '0;
    src_steady          = 1'b0;
    sink_steady         = 1'b0;
    hold_reqs           = 0;
    n_samples           = 0;
    n_clears            = 0;
    n_absent            = 0;
    n_settings          = 0;
    for (int k = 0; k < NumEvents; k++) begin
      prev_reading[k] = '0;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_regs(8'd1, 8'd1, 8'd6, 8'd0, 8'd0, 8'h3F, 1'b1);
    send(CmdClear, 8'd0, 4'd6, ramp('0, '0));
    send(CmdSample, 8'd0, 4'd6, ramp(64'd1000, 64'd100));
    send(CmdSample, 8'd0, 4'd6, ramp(64'd1500, 64'd7));
    send(CmdSample, 8'd0, 4'd6, ramp('1, '0));
    send(CmdSample, 8'd0, 4'd6, ramp(64'd3, 64'd1));
    send(CmdSample, 8'd0, 4'd6, ramp('0, '0));
    send(CmdSample, 8'd0, 4'd6, ramp(64'd50, 64'd1));
    send(CmdSample, 8'd0, 4'd0, ramp(64'd80, 64'd1));
    send(CmdSample, 8'd0, 4'd3, ramp(64'd90, 64'd1));
    send(CmdSample, 8'd0, 4'd7, ramp(64'd99, 64'd1));
    send(CmdSample, 8'd0, 4'd15, ramp(64'hAAAA_AAAA_AAAA_AAAA, '0));
    send(CmdSample, 8'd0, 4'd15, ramp(64'h5555_5555_5555_5555, '0));
    send(CmdSample, 8'd15, 4'd6, ramp(64'hFFFF_FFFF_0000_0001, 64'd1));
    send(CmdClear, 8'd15, 4'd6, ramp('0, '0));
    send(CmdSample, 8'd15, 4'd6, ramp(64'd7, 64'd1));
    send(CmdSample, 8'd16, 4'd6, ramp(64'd5, 64'd1));
    send(CmdSample, 8'd255, 4'd15, ramp('1, '0));
    send(CmdClear, 8'd255, 4'd15, ramp('1, '0));

    settle();
    set_regs(8'hFE, 8'd255, 8'd255, 8'd1, 8'd0, 8'h3F, 1'b0);
    send(CmdSample, 8'd1, 4'd6, ramp(64'd9, 64'd1));
    settle();
    set_regs(8'd1, 8'd0, 8'd255, 8'd1, 8'd0, 8'h3F, 1'b0);
    send(CmdSample, 8'd1, 4'd6, ramp(64'd9, 64'd1));
    settle();
    set_regs(8'd1, 8'd255, 8'd255, 8'd1, 8'h09, 8'hFF, 1'b0);
    send(CmdSample, 8'd2, 4'd6, ramp(64'd4, 64'd1));
    send(CmdSample, 8'd2, 4'd6, ramp(64'd7, 64'd3));
    settle();
    set_regs(8'd1, 8'd2, 8'd3, 8'd63, 8'd0, 8'h2A, 1'b0);
    send(CmdSample, 8'd3, 4'd6, ramp(64'h7FFF_FFFF_FFFF_FFF0, 64'd1));
    send(CmdSample, 8'd3, 4'd6, ramp(64'd2, 64'd1));
    settle();
    set_regs(8'd1, 8'd2, 8'd1, 8'd64, 8'd0, 8'h00, 1'b0);
    send(CmdSample, 8'd3, 4'd6, ramp(64'd2, 64'd1));
    settle();
    set_regs(8'd1, 8'd2, 8'd6, 8'd64, 8'hFF, 8'h3F, 1'b0);
    send(CmdClear, 8'd3, 4'd6, ramp(64'd2, 64'd1));
    settle();
    set_regs(8'd1, 8'd3, 8'd6, 8'd255, 8'h84, 8'h3F, 1'b0);
    send(CmdSample, 8'd4, 4'd6, ramp(64'd11, 64'd1));
    send(CmdSample, 8'd4, 4'd6, ramp(64'd10, 64'd1));

    for (int p = 0; p < RandPhases; p++) begin
      settle();
      random_regs();
      src_steady  <= (p == 2) || (p == 5);
      sink_steady <= (p == 3) || (p == 5);
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == 4 && i == 20) begin
          hold_reqs <= hold_reqs + 1;
        end
        random_item();
      end
    end

    settle();
    $display("Ran %0d sample and %0d clear transactions (%0d to absent cpus) over %0d settings.",
             n_samples, n_clears, n_absent, n_settings);
    $display("Compared %0d results against predicted deltas.", checked);
    if (fails == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
